// ----- src/rgbrle_pkg.sv -----
// shared types, constants and helpers for the rgb565 run-length frame encoder
// no dependencies

package rgbrle_pkg;

  localparam int PKT_BYTES = 9;
  localparam int CNT_W     = $clog2(PKT_BYTES + 1);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [7:0]  MAGIC       = 8'hFE;
  localparam logic [7:0]  MAX_RUN     = 8'd255;
  localparam logic        ENABLE_RST  = 1'b0;
  localparam logic [15:0] OVF_RST     = 16'd32000;
  localparam logic [15:0] TAIL_RST    = 16'd32765;
  localparam logic [9:0]  CHUNK_RST   = 10'd480;
  localparam logic [9:0]  CHUNK_MAX   = 10'd512;
  localparam logic        MODE_HEADER = 1'b0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE         = 2'd0,
    REG_OVERFLOW_LIMIT = 2'd1,
    REG_TAIL_LIMIT     = 2'd2,
    REG_CHUNK_SIZE     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic        enable;
    logic [15:0] overflow_limit;
    logic [15:0] tail_limit;
    logic [9:0]  chunk_size;
  } cfg_t;

  // bytes of one input item plus chunk/frame bookkeeping
  typedef struct packed {
    logic [PKT_BYTES-1:0][7:0] byte_arr;
    logic [CNT_W-1:0]          cnt;
    logic                      frame_end;
    logic                      pre_clear;
    logic                      post_clear;
  } pkt_t;

  function automatic logic [15:0] sat_add3(input logic [15:0] v);
    logic [16:0] s;
    s = {1'b0, v} + 17'd3;
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

endpackage

// ----- src/rgbrle_ifs.sv -----
// channel interfaces: pixel/header input, byte output, configuration writes
// depends on rgbrle_pkg

interface rgbrle_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] region_x;
  logic [15:0] region_y;
  logic [15:0] region_w;
  logic [15:0] region_h;
  logic [15:0] pixel;

  modport src (output valid, mode, region_x, region_y, region_w, region_h, pixel,
               input ready);
  modport snk (input valid, mode, region_x, region_y, region_w, region_h, pixel,
               output ready);
endinterface

interface rgbrle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       chunk_end;
  logic       frame_end;
  logic       last_of_item;

  modport src (output valid, out_byte, chunk_end, frame_end, last_of_item, input ready);
  modport snk (input valid, out_byte, chunk_end, frame_end, last_of_item, output ready);
endinterface

interface rgbrle_cfg_if import rgbrle_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport src (output valid, index, data, input ready);
  modport snk (input valid, index, data, output ready);
endinterface

// ----- src/rgbrle_core.sv -----
// input register, frame/run state and per-item byte packet builder
// depends on rgbrle_pkg and rgbrle_ifs

module rgbrle_core import rgbrle_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  rgbrle_in_if.snk     pix_in,
  output pkt_t         pkt,
  output logic         pkt_valid,
  input  logic         pkt_ready
);

  logic        in_valid;
  logic        in_mode;
  logic [15:0] in_x;
  logic [15:0] in_y;
  logic [15:0] in_w;
  logic [15:0] in_h;
  logic [15:0] in_pixel;

  logic        frame_active;
  logic        stopped_by_overflow;
  logic [15:0] run_pixel;
  logic [7:0]  run_length;
  logic [31:0] pixels_left;
  logic [15:0] bytes_emitted;

  logic        frame_active_next;
  logic        stopped_by_overflow_next;
  logic [15:0] run_pixel_next;
  logic [7:0]  run_length_next;
  logic [31:0] pixels_left_next;
  logic [15:0] bytes_emitted_next;
  pkt_t        pkt_next;
  logic        pkt_make;
  logic        advance;

  assign advance      = in_valid && (!pkt_valid || pkt_ready);
  assign pix_in.ready = !in_valid || advance;

  always_comb begin
    frame_active_next        = frame_active;
    stopped_by_overflow_next = stopped_by_overflow;
    run_pixel_next           = run_pixel;
    run_length_next          = run_length;
    pixels_left_next         = pixels_left;
    bytes_emitted_next       = bytes_emitted;
    pkt_next                 = '0;
    pkt_make                 = 1'b0;
    if (in_mode == MODE_HEADER) begin
      if (cfg.enable) begin
        pkt_next.byte_arr[0] = MAGIC;
        pkt_next.byte_arr[1] = in_x[7:0];
        pkt_next.byte_arr[2] = in_x[15:8];
        pkt_next.byte_arr[3] = in_y[7:0];
        pkt_next.byte_arr[4] = in_y[15:8];
        pkt_next.byte_arr[5] = in_w[7:0];
        pkt_next.byte_arr[6] = in_w[15:8];
        pkt_next.byte_arr[7] = in_h[7:0];
        pkt_next.byte_arr[8] = in_h[15:8];
        pkt_next.cnt         = CNT_W'(PKT_BYTES);
        pkt_next.pre_clear   = 1'b1;
        bytes_emitted_next       = 16'(PKT_BYTES);
        run_pixel_next           = '0;
        run_length_next          = '0;
        frame_active_next        = 1'b0;
        stopped_by_overflow_next = 1'b0;
        pixels_left_next         = {16'd0, in_w} * {16'd0, in_h};
        if (in_w == '0 || in_h == '0) begin
          pkt_next.frame_end  = 1'b1;
          pkt_next.post_clear = 1'b1;
        end else begin
          frame_active_next = 1'b1;
          if (16'(PKT_BYTES) > cfg.overflow_limit && 16'(PKT_BYTES) >= cfg.tail_limit) begin
            stopped_by_overflow_next = 1'b1;
            pkt_next.frame_end       = 1'b1;
            pkt_next.post_clear      = 1'b1;
          end
        end
        pkt_make = 1'b1;
      end
    end else if (frame_active) begin
      if (!stopped_by_overflow) begin
        if (run_length == '0) begin
          run_pixel_next  = in_pixel;
          run_length_next = 8'd1;
        end else if (in_pixel == run_pixel && run_length != MAX_RUN) begin
          run_length_next = run_length + 8'd1;
        end else begin
          pkt_next.byte_arr[0] = run_length;
          pkt_next.byte_arr[1] = run_pixel[7:0];
          pkt_next.byte_arr[2] = run_pixel[15:8];
          pkt_next.cnt         = CNT_W'(3);
          bytes_emitted_next   = sat_add3(bytes_emitted);
          run_pixel_next       = in_pixel;
          run_length_next      = 8'd1;
        end
      end
      if (pixels_left != '0) begin
        pixels_left_next = pixels_left - 32'd1;
      end
      if (!stopped_by_overflow &&
          (bytes_emitted_next > cfg.overflow_limit || pixels_left_next == '0)) begin
        if (bytes_emitted_next < cfg.tail_limit) begin
          if (pkt_next.cnt == '0) begin
            pkt_next.byte_arr[0] = run_length_next;
            pkt_next.byte_arr[1] = run_pixel_next[7:0];
            pkt_next.byte_arr[2] = run_pixel_next[15:8];
          end else begin
            pkt_next.byte_arr[3] = run_length_next;
            pkt_next.byte_arr[4] = run_pixel_next[7:0];
            pkt_next.byte_arr[5] = run_pixel_next[15:8];
          end
          pkt_next.cnt       = pkt_next.cnt + CNT_W'(3);
          bytes_emitted_next = sat_add3(bytes_emitted_next);
        end
        run_length_next          = '0;
        pkt_next.frame_end       = 1'b1;
        pkt_next.post_clear      = 1'b1;
        stopped_by_overflow_next = 1'b1;
      end
      if (pixels_left_next == '0) begin
        frame_active_next        = 1'b0;
        stopped_by_overflow_next = 1'b0;
        run_length_next          = '0;
      end
      pkt_make = (pkt_next.cnt != '0) || pkt_next.post_clear;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid            <= 1'b0;
      pkt_valid           <= 1'b0;
      frame_active        <= 1'b0;
      stopped_by_overflow <= 1'b0;
      run_pixel           <= '0;
      run_length          <= '0;
      pixels_left         <= '0;
      bytes_emitted       <= '0;
    end else begin
      if (pix_in.ready) begin
        in_valid <= pix_in.valid;
      end
      if (advance) begin
        pkt_valid           <= pkt_make;
        frame_active        <= frame_active_next;
        stopped_by_overflow <= stopped_by_overflow_next;
        run_pixel           <= run_pixel_next;
        run_length          <= run_length_next;
        pixels_left         <= pixels_left_next;
        bytes_emitted       <= bytes_emitted_next;
      end else if (pkt_ready) begin
        pkt_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_in.valid && pix_in.ready) begin
      in_mode  <= pix_in.mode;
      in_x     <= pix_in.region_x;
      in_y     <= pix_in.region_y;
      in_w     <= pix_in.region_w;
      in_h     <= pix_in.region_h;
      in_pixel <= pix_in.pixel;
    end
    if (advance && pkt_make) begin
      pkt <= pkt_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst) !frame_active |-> run_length == '0)
    else $error("open run outside a frame");
  assert property (@(posedge clk) disable iff (rst) stopped_by_overflow |-> frame_active)
    else $error("overflow stop without an active frame");
  assert property (@(posedge clk) disable iff (rst)
    pkt_valid && !pkt_ready |=> pkt_valid && $stable(pkt))
    else $error("packet changed while waiting");

endmodule

// ----- src/rgbrle_ser.sv -----
// byte serializer with chunk counting and registered output stage
// depends on rgbrle_pkg and rgbrle_ifs

module rgbrle_ser import rgbrle_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  pkt_t     pkt,
  input  logic     pkt_valid,
  output logic     pkt_ready,
  rgbrle_out_if.src byte_out
);

  pkt_t             work;
  logic             busy;
  logic [CNT_W-1:0] idx;
  logic [8:0]       fill;
  logic [8:0]       fill_next;
  logic             busy_next;

  logic             o_valid;
  logic [7:0]       o_byte;
  logic             o_chunk_end;
  logic             o_frame_end;
  logic             o_last;

  logic [9:0]       eff_chunk;
  logic             emit;
  logic             last;
  logic             hit;
  logic             load;

  assign byte_out.valid        = o_valid;
  assign byte_out.out_byte     = o_byte;
  assign byte_out.chunk_end    = o_chunk_end;
  assign byte_out.frame_end    = o_frame_end;
  assign byte_out.last_of_item = o_last;

  always_comb begin
    if (cfg.chunk_size == '0) begin
      eff_chunk = 10'd1;
    end else if (cfg.chunk_size > CHUNK_MAX) begin
      eff_chunk = CHUNK_MAX;
    end else begin
      eff_chunk = cfg.chunk_size;
    end
  end

  assign emit      = busy && (!o_valid || byte_out.ready);
  assign last      = (idx == work.cnt - CNT_W'(1));
  assign hit       = ({1'b0, fill} + 10'd1) >= eff_chunk;
  assign pkt_ready = !busy || (emit && last);
  assign load      = pkt_valid && pkt_ready;

  always_comb begin
    fill_next = fill;
    busy_next = busy;
    if (emit) begin
      fill_next = (hit || (last && work.post_clear)) ? '0 : fill + 9'd1;
      if (last) begin
        busy_next = 1'b0;
      end
    end
    if (load) begin
      busy_next = (pkt.cnt != '0);
      if (pkt.pre_clear || (pkt.cnt == '0 && pkt.post_clear)) begin
        fill_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      fill    <= '0;
      o_valid <= 1'b0;
    end else begin
      busy <= busy_next;
      fill <= fill_next;
      if (emit) begin
        o_valid <= 1'b1;
      end else if (byte_out.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      work <= pkt;
      idx  <= '0;
    end else if (emit) begin
      idx <= idx + CNT_W'(1);
    end
    if (emit) begin
      o_byte      <= work.byte_arr[idx];
      o_chunk_end <= hit || (last && work.frame_end);
      o_frame_end <= last && work.frame_end;
      o_last      <= last;
    end
  end

  assert property (@(posedge clk) disable iff (rst) busy |-> idx < work.cnt)
    else $error("byte index past packet length");
  assert property (@(posedge clk) disable iff (rst) load && pkt.pre_clear |=> fill == '0)
    else $error("chunk fill not cleared at frame start");
  assert property (@(posedge clk) disable iff (rst)
    pkt_valid && busy && !(emit && last) |-> !pkt_ready)
    else $error("packet taken while serializer busy");

endmodule

// ----- src/rgb565_rle_frame_encoder_top.sv -----
// top level of the rgb565 run-length frame encoder: config registers, core, serializer
// depends on rgbrle_pkg, rgbrle_ifs, rgbrle_core and rgbrle_ser
// path: core input and packet registers, then serializer work and output registers
// throughput: one output byte per cycle while byte_out.ready is high; bytes per item:
// header 9 (0 if disabled), pixel 0, 3 or 6; empty items one per cycle unless stalled
// reset: synchronous rst clears frame and run state, config returns to defaults

module rgb565_rle_frame_encoder_top import rgbrle_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  rgbrle_cfg_if.snk cfg,
  rgbrle_in_if.snk  pix_in,
  rgbrle_out_if.src byte_out
);

  cfg_t cfg_regs;
  pkt_t pkt;
  logic pkt_valid;
  logic pkt_ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.enable         <= ENABLE_RST;
      cfg_regs.overflow_limit <= OVF_RST;
      cfg_regs.tail_limit     <= TAIL_RST;
      cfg_regs.chunk_size     <= CHUNK_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_ENABLE:         cfg_regs.enable         <= cfg.data[0];
        REG_OVERFLOW_LIMIT: cfg_regs.overflow_limit <= cfg.data[15:0];
        REG_TAIL_LIMIT:     cfg_regs.tail_limit     <= cfg.data[15:0];
        REG_CHUNK_SIZE:     cfg_regs.chunk_size     <= cfg.data[9:0];
        default: ;
      endcase
    end
  end

  rgbrle_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_regs),
    .pix_in    (pix_in),
    .pkt       (pkt),
    .pkt_valid (pkt_valid),
    .pkt_ready (pkt_ready)
  );

  rgbrle_ser u_ser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_regs),
    .pkt       (pkt),
    .pkt_valid (pkt_valid),
    .pkt_ready (pkt_ready),
    .byte_out  (byte_out)
  );

endmodule
